// ===== src/fprx_pkg.sv =====
// Shared types and constants for the framed packet receiver.
package fprx_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;

    localparam logic [7:0] START_MARKER_RST = 8'h02;
    localparam logic [7:0] END_MARKER_RST   = 8'h03;

    // configuration register indexes
    localparam logic CFG_START_MARKER = 1'b0;
    localparam logic CFG_END_MARKER   = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LENGTH,
        PH_DATA,
        PH_CHECK,
        PH_END,
        PH_REPLAY
    } t_phase;

    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_EMPTY   = 3'd1,
        KIND_BADCHK  = 3'd2,
        KIND_NOEND   = 3'd3,
        KIND_TOOLONG = 3'd4
    } t_kind;

endpackage

// ===== src/framed_packet_receiver_xor_core.sv =====
// Top level of the framed packet receiver with XOR checksum.
//
// Usage
//   Input channel: one received byte per transaction (i_valid / o_stall).
//   The parser hunts for the start marker, takes a length byte, stores that
//   many payload bytes in a RAM while folding them into a running XOR, then
//   checks the checksum byte and the end marker.
//   Output channel (o_valid / i_stall): a good frame is replayed from the RAM
//   as one transaction per payload byte, the final one flagged by o_last. A
//   good empty frame gives one empty-frame transaction; a bad checksum, a
//   missing end marker or an oversize length give one error transaction each.
//   An error or empty-frame result is registered and appears in the cycle
//   after the byte that causes it; the first payload byte of a replay
//   passes through the RAM read register and then the output register, and
//   the rest follow one per cycle while the receiver does not stall.
//   Input: one byte per cycle while parsing and the output is not stalled;
//   a good frame holds the input after its end marker until its replay ends.
//   The single output register is freed in the cycle it is taken, so a
//   receiver that never stalls sees no bubbles during replay.
//   When the receiver stalls, the output register holds and o_stall is raised
//   toward the sender; the replay pointer waits on the same entry.
//   Reset (synchronous, active low) returns the parser to hunting and loads
//   the marker registers with their defaults; the RAM is not cleared.
//   Configuration writes are meant for idle periods only.
module framed_packet_receiver_xor_core #(
    parameter int MAX_PAYLOAD = fprx_pkg::MAX_PAYLOAD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    // output channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_kind,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_received_check,
    output logic [7:0] o_expected_check,
    output logic [7:0] o_frame_length,
    output logic       o_last
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    // marker registers
    logic [7:0] r_start_marker;
    logic [7:0] r_end_marker;

    // parser state
    fprx_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_exp_cnt, n_exp_cnt;
    logic [CW-1:0]    r_fill_idx, n_fill_idx;
    logic [7:0]       r_xor, n_xor;
    logic [CW-1:0]    r_rd_idx, n_rd_idx;

    // output register
    logic             r_out_valid, n_out_valid;
    fprx_pkg::t_kind  r_kind, n_kind;
    logic [7:0]       r_payload, n_payload;
    logic [7:0]       r_rcv_chk, n_rcv_chk;
    logic [7:0]       r_exp_chk, n_exp_chk;
    logic [7:0]       r_len, n_len;
    logic             r_last, n_last;

    // RAM ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_rdata;

    logic in_acc;
    logic out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= fprx_pkg::START_MARKER_RST;
            r_end_marker   <= fprx_pkg::END_MARKER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fprx_pkg::CFG_START_MARKER: r_start_marker <= i_cfg_data;
                fprx_pkg::CFG_END_MARKER:   r_end_marker   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output slot can take a new result this cycle
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_phase == fprx_pkg::PH_REPLAY) || !out_free;
    assign in_acc   = i_valid && !o_stall;

    assign ram_waddr = r_fill_idx[AW-1:0];

    always_comb begin
        n_phase     = r_phase;
        n_exp_cnt   = r_exp_cnt;
        n_fill_idx  = r_fill_idx;
        n_xor       = r_xor;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid && i_stall;
        n_kind      = r_kind;
        n_payload   = r_payload;
        n_rcv_chk   = r_rcv_chk;
        n_exp_chk   = r_exp_chk;
        n_len       = r_len;
        n_last      = r_last;
        ram_we      = 1'b0;

        case (r_phase)
            fprx_pkg::PH_LENGTH: begin
                if (in_acc) begin
                    n_exp_cnt  = i_rx_byte;
                    n_fill_idx = '0;
                    n_xor      = '0;
                    if (i_rx_byte > MAX_LEN) begin
                        n_out_valid = 1'b1;
                        n_kind      = fprx_pkg::KIND_TOOLONG;
                        n_payload   = '0;
                        n_rcv_chk   = '0;
                        n_exp_chk   = '0;
                        n_len       = i_rx_byte;
                        n_last      = 1'b1;
                        n_phase     = fprx_pkg::PH_HUNT;
                    end else if (i_rx_byte == 8'd0) begin
                        n_phase = fprx_pkg::PH_CHECK;
                    end else begin
                        n_phase = fprx_pkg::PH_DATA;
                    end
                end
            end

            fprx_pkg::PH_DATA: begin
                if (in_acc) begin
                    ram_we     = 1'b1;
                    n_xor      = r_xor ^ i_rx_byte;
                    n_fill_idx = r_fill_idx + 1'b1;
                    if (8'(n_fill_idx) >= r_exp_cnt) begin
                        n_phase = fprx_pkg::PH_CHECK;
                    end
                end
            end

            fprx_pkg::PH_CHECK: begin
                if (in_acc) begin
                    if (i_rx_byte == r_xor) begin
                        n_phase = fprx_pkg::PH_END;
                    end else begin
                        n_out_valid = 1'b1;
                        n_kind      = fprx_pkg::KIND_BADCHK;
                        n_payload   = '0;
                        n_rcv_chk   = i_rx_byte;
                        n_exp_chk   = r_xor;
                        n_len       = r_exp_cnt;
                        n_last      = 1'b1;
                        n_phase     = fprx_pkg::PH_HUNT;
                    end
                end
            end

            fprx_pkg::PH_END: begin
                if (in_acc) begin
                    n_phase = fprx_pkg::PH_HUNT;
                    if (i_rx_byte != r_end_marker) begin
                        n_out_valid = 1'b1;
                        n_kind      = fprx_pkg::KIND_NOEND;
                        n_payload   = '0;
                        n_rcv_chk   = '0;
                        n_exp_chk   = '0;
                        n_len       = r_exp_cnt;
                        n_last      = 1'b1;
                    end else if (r_exp_cnt == 8'd0) begin
                        n_out_valid = 1'b1;
                        n_kind      = fprx_pkg::KIND_EMPTY;
                        n_payload   = '0;
                        n_rcv_chk   = '0;
                        n_exp_chk   = '0;
                        n_len       = '0;
                        n_last      = 1'b1;
                    end else begin
                        // entry 0 is read now, its data is ready next cycle
                        n_rd_idx = '0;
                        n_phase  = fprx_pkg::PH_REPLAY;
                    end
                end
            end

            fprx_pkg::PH_REPLAY: begin
                // ram_rdata holds entry r_rd_idx; address follows n_rd_idx
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = fprx_pkg::KIND_DATA;
                    n_payload   = ram_rdata;
                    n_rcv_chk   = '0;
                    n_exp_chk   = '0;
                    n_len       = r_exp_cnt;
                    if (8'(r_rd_idx) + 8'd1 == r_exp_cnt) begin
                        n_last   = 1'b1;
                        n_rd_idx = '0;
                        n_phase  = fprx_pkg::PH_HUNT;
                    end else begin
                        n_last   = 1'b0;
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                end
            end

            default: begin
                // hunting, and any unused code
                n_phase = fprx_pkg::PH_HUNT;
                if (in_acc && i_rx_byte == r_start_marker) begin
                    n_phase = fprx_pkg::PH_LENGTH;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= fprx_pkg::PH_HUNT;
            r_exp_cnt   <= '0;
            r_fill_idx  <= '0;
            r_xor       <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_exp_cnt   <= n_exp_cnt;
            r_fill_idx  <= n_fill_idx;
            r_xor       <= n_xor;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_payload <= n_payload;
        r_rcv_chk <= n_rcv_chk;
        r_exp_chk <= n_exp_chk;
        r_len     <= n_len;
        r_last    <= n_last;
    end

    fprx_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_rx_byte),
        .i_raddr (n_rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_valid          = r_out_valid;
    assign o_kind           = r_kind;
    assign o_payload_byte   = r_payload;
    assign o_received_check = r_rcv_chk;
    assign o_expected_check = r_exp_chk;
    assign o_frame_length   = r_len;
    assign o_last           = r_last;

    // no new byte is taken while the stored payload is being replayed
    a_replay_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == fprx_pkg::PH_REPLAY |-> o_stall)
        else $error("input accepted during replay");

    // fill pointer never passes the buffer size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill_idx) <= MAX_PAYLOAD)
        else $error("fill index beyond buffer");

    // only payload results may be non-final
    a_nonlast_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_kind == fprx_pkg::KIND_DATA)
        else $error("non-final result that is not payload");

    // replay streams without bubbles once a byte is taken
    a_replay_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid)
        else $error("gap inside frame replay");

endmodule

// ===== src/fprx_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module fprx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
